@@ design/rqy_pkg.sv @@
// Shared types, coefficient tables and helpers for the RGB quad to YUV 4:2:0 converter.
// No dependencies.
package rqy_pkg;

    localparam int PIX_W   = 8;
    localparam int LUMA_PW = 16;
    localparam int CHR_PW  = 18;

    localparam logic CFG_FULL_RANGE    = 1'b0;
    localparam logic CFG_SWAP_RED_BLUE = 1'b1;

    localparam logic [PIX_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic signed [10:0] CHR_OFFSET  = 11'sd128;

    typedef struct packed {
        logic [7:0] kr;
        logic [7:0] kg;
        logic [7:0] kb;
    } luma_coef_t;

    typedef struct packed {
        logic signed [8:0] kr;
        logic signed [8:0] kg;
        logic signed [8:0] kb;
    } chroma_coef_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic load;
        logic full_range;
    } lane_ctrl_t;

    function automatic luma_coef_t luma_coef(input logic full_range);
        luma_coef_t c;
        if (full_range)
        begin
            c.kr = 8'd54;
            c.kg = 8'd183;
            c.kb = 8'd18;
        end
        else
        begin
            c.kr = 8'd46;
            c.kg = 8'd157;
            c.kb = 8'd15;
        end
        return c;
    endfunction

    function automatic chroma_coef_t u_coef(input logic full_range);
        chroma_coef_t c;
        if (full_range)
        begin
            c.kr = -9'sd29;
            c.kg = -9'sd98;
            c.kb = 9'sd127;
        end
        else
        begin
            c.kr = -9'sd25;
            c.kg = -9'sd86;
            c.kb = 9'sd112;
        end
        return c;
    endfunction

    function automatic chroma_coef_t v_coef(input logic full_range);
        chroma_coef_t c;
        if (full_range)
        begin
            c.kr = 9'sd127;
            c.kg = -9'sd115;
            c.kb = -9'sd11;
        end
        else
        begin
            c.kr = 9'sd112;
            c.kg = -9'sd102;
            c.kb = -9'sd10;
        end
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [10:0] v);
        logic [PIX_W-1:0] r;
        if (v < 11'sd0)
            r = 8'd0;
        else if (v > 11'sd255)
            r = 8'd255;
        else
            r = v[PIX_W-1:0];
        return r;
    endfunction

endpackage

@@ design/rqy_luma_lane.sv @@
// One luma lane: registered weighted products, then sum, shift, video-range offset and clamp.
// Depends on rqy_pkg.
module rqy_luma_lane
    import rqy_pkg::*;
(
    input  logic             clk,
    input  lane_ctrl_t       ctrl,
    input  pixel_t           pix,
    output logic [PIX_W-1:0] luma
);

    luma_coef_t         coef;
    logic [LUMA_PW-1:0] prod_r_reg;
    logic [LUMA_PW-1:0] prod_g_reg;
    logic [LUMA_PW-1:0] prod_b_reg;
    logic [LUMA_PW:0]   sum;
    logic signed [10:0] y;

    assign coef = luma_coef(ctrl.full_range);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_r_reg <= LUMA_PW'(pix.red) * LUMA_PW'(coef.kr);
            prod_g_reg <= LUMA_PW'(pix.green) * LUMA_PW'(coef.kg);
            prod_b_reg <= LUMA_PW'(pix.blue) * LUMA_PW'(coef.kb);
        end
    end

    always_comb
    begin
        sum = {1'b0, prod_r_reg} + {1'b0, prod_g_reg} + {1'b0, prod_b_reg};
        y   = $signed({2'b00, sum[LUMA_PW:8]});
        if (!ctrl.full_range)
            y = y + $signed({3'b000, LUMA_OFFSET});
        luma = clamp_byte(y);
    end

endmodule

@@ design/rqy_chroma_merge.sv @@
// Merging stage: averages the four lanes' pixels, forms U and V with floor shift and clamp.
// Depends on rqy_pkg.
module rqy_chroma_merge
    import rqy_pkg::*;
(
    input  logic             clk,
    input  lane_ctrl_t       ctrl,
    input  pixel_t           pix [4],
    output logic [PIX_W-1:0] chroma_blue,
    output logic [PIX_W-1:0] chroma_red
);

    chroma_coef_t            uc;
    chroma_coef_t            vc;
    logic [PIX_W+1:0]        sum_r;
    logic [PIX_W+1:0]        sum_g;
    logic [PIX_W+1:0]        sum_b;
    logic signed [PIX_W:0]   avg_r;
    logic signed [PIX_W:0]   avg_g;
    logic signed [PIX_W:0]   avg_b;
    logic signed [CHR_PW-1:0] pu_r_reg;
    logic signed [CHR_PW-1:0] pu_g_reg;
    logic signed [CHR_PW-1:0] pu_b_reg;
    logic signed [CHR_PW-1:0] pv_r_reg;
    logic signed [CHR_PW-1:0] pv_g_reg;
    logic signed [CHR_PW-1:0] pv_b_reg;
    logic signed [CHR_PW-1:0] su;
    logic signed [CHR_PW-1:0] sv;
    logic signed [10:0]       u;
    logic signed [10:0]       v;

    assign uc = u_coef(ctrl.full_range);
    assign vc = v_coef(ctrl.full_range);

    always_comb
    begin
        sum_r = 10'(pix[0].red) + 10'(pix[1].red) + 10'(pix[2].red) + 10'(pix[3].red);
        sum_g = 10'(pix[0].green) + 10'(pix[1].green) + 10'(pix[2].green)
              + 10'(pix[3].green);
        sum_b = 10'(pix[0].blue) + 10'(pix[1].blue) + 10'(pix[2].blue) + 10'(pix[3].blue);
        avg_r = $signed({1'b0, sum_r[PIX_W+1:2]});
        avg_g = $signed({1'b0, sum_g[PIX_W+1:2]});
        avg_b = $signed({1'b0, sum_b[PIX_W+1:2]});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pu_r_reg <= avg_r * uc.kr;
            pu_g_reg <= avg_g * uc.kg;
            pu_b_reg <= avg_b * uc.kb;
            pv_r_reg <= avg_r * vc.kr;
            pv_g_reg <= avg_g * vc.kg;
            pv_b_reg <= avg_b * vc.kb;
        end
    end

    always_comb
    begin
        su = pu_r_reg + pu_g_reg + pu_b_reg;
        sv = pv_r_reg + pv_g_reg + pv_b_reg;
        u  = 11'(su >>> 8) + CHR_OFFSET;
        v  = 11'(sv >>> 8) + CHR_OFFSET;
        chroma_blue = clamp_byte(u);
        chroma_red  = clamp_byte(v);
    end

endmodule

@@ design/rgb_quad_to_yuv420.sv @@
// Top level of the RGB 2x2 quad to YUV 4:2:0 converter (BT.709, 8.8 fixed point).
// Depends on rqy_pkg, rqy_luma_lane and rqy_chroma_merge.
//
// Usage:
//   Input channel: in_valid / in_stall carry one 2x2 quad of 8-bit pixels per
//   request; it is taken at a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall carry four luma bytes and one U and
//   one V byte per request.
//   Configuration: cfg_write with cfg_index and cfg_data sets full_range (index 0)
//   and swap_red_blue (index 1); write only while no request is in flight.
//   Pipeline: a request passes through one product register stage in the luma
//   lanes and chroma merge, then the output register that drives out_valid.
//   Throughput: one quad per cycle while out_stall stays low.
//   Stall: a stalled result holds on the outputs; the product stage, if empty,
//   still takes one more quad, after which in_stall rises until the output is taken.
//   Reset: both pipeline stages empty, full_range and swap_red_blue clear
//   (video range, R,G,B byte order).
module rgb_quad_to_yuv420
    import rqy_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic             cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] top_left_c0,
    input  logic [PIX_W-1:0] top_left_c1,
    input  logic [PIX_W-1:0] top_left_c2,
    input  logic [PIX_W-1:0] top_right_c0,
    input  logic [PIX_W-1:0] top_right_c1,
    input  logic [PIX_W-1:0] top_right_c2,
    input  logic [PIX_W-1:0] bottom_left_c0,
    input  logic [PIX_W-1:0] bottom_left_c1,
    input  logic [PIX_W-1:0] bottom_left_c2,
    input  logic [PIX_W-1:0] bottom_right_c0,
    input  logic [PIX_W-1:0] bottom_right_c1,
    input  logic [PIX_W-1:0] bottom_right_c2,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] luma_top_left,
    output logic [PIX_W-1:0] luma_top_right,
    output logic [PIX_W-1:0] luma_bottom_left,
    output logic [PIX_W-1:0] luma_bottom_right,
    output logic [PIX_W-1:0] chroma_blue,
    output logic [PIX_W-1:0] chroma_red
);

    logic             full_range_reg;
    logic             swap_reg;
    logic             v1_reg;
    logic             v1_next;
    logic             v2_reg;
    logic             v2_next;
    logic             adv1;
    logic             adv2;
    lane_ctrl_t       ctrl;
    logic [PIX_W-1:0] raw [4][3];
    pixel_t           pix [4];
    logic [PIX_W-1:0] luma [4];
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic [PIX_W-1:0] luma_reg [4];
    logic [PIX_W-1:0] cb_reg;
    logic [PIX_W-1:0] cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_range_reg <= 1'b0;
            swap_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FULL_RANGE:    full_range_reg <= cfg_data;
                CFG_SWAP_RED_BLUE: swap_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // advance each stage when empty or when the next one moves
    always_comb
    begin
        adv2    = !v2_reg || !out_stall;
        adv1    = !v1_reg || adv2;
        v1_next = adv1 ? in_valid : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
    end

    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    assign ctrl.load       = adv1 && in_valid;
    assign ctrl.full_range = full_range_reg;

    assign raw[0] = '{top_left_c0, top_left_c1, top_left_c2};
    assign raw[1] = '{top_right_c0, top_right_c1, top_right_c2};
    assign raw[2] = '{bottom_left_c0, bottom_left_c1, bottom_left_c2};
    assign raw[3] = '{bottom_right_c0, bottom_right_c1, bottom_right_c2};

    for (genvar p = 0; p < 4; p++)
    begin : g_lane
        assign pix[p].red   = swap_reg ? raw[p][2] : raw[p][0];
        assign pix[p].green = raw[p][1];
        assign pix[p].blue  = swap_reg ? raw[p][0] : raw[p][2];

        rqy_luma_lane u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .pix  (pix[p]),
            .luma (luma[p])
        );
    end

    rqy_chroma_merge u_merge (
        .clk         (clk),
        .ctrl        (ctrl),
        .pix         (pix),
        .chroma_blue (cb),
        .chroma_red  (cr)
    );

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            luma_reg <= luma;
            cb_reg   <= cb;
            cr_reg   <= cr;
        end
    end

    assign out_valid         = v2_reg;
    assign luma_top_left     = luma_reg[0];
    assign luma_top_right    = luma_reg[1];
    assign luma_bottom_left  = luma_reg[2];
    assign luma_bottom_right = luma_reg[3];
    assign chroma_blue       = cb_reg;
    assign chroma_red        = cr_reg;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for rgb_quad_to_yuv420: directed corner quads, mode sweeps,
// receiver hold-off and random traffic, each result compared with a local BT.709 predictor.
// Depends on rqy_pkg and the design files only.
module testbench;
    import rqy_pkg::*;

    typedef logic [11:0][PIX_W-1:0] quad_t;
    typedef logic [5:0][PIX_W-1:0]  yuv_t;

    localparam int CYCLE_LIMIT = 200000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_write;
    logic             cfg_index;
    logic             cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [PIX_W-1:0] top_left_c0, top_left_c1, top_left_c2;
    logic [PIX_W-1:0] top_right_c0, top_right_c1, top_right_c2;
    logic [PIX_W-1:0] bottom_left_c0, bottom_left_c1, bottom_left_c2;
    logic [PIX_W-1:0] bottom_right_c0, bottom_right_c1, bottom_right_c2;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right;
    logic [PIX_W-1:0] chroma_blue, chroma_red;

    yuv_t  yuv_expected[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    mode_full_range = 1'b0;
    bit    mode_swap_rb = 1'b0;
    bit    gaps_on = 1'b0;
    logic  stalls_on = 1'b0;
    logic  hold_off = 1'b0;
    string yuv_field[6] = '{"luma_top_left", "luma_top_right", "luma_bottom_left",
                            "luma_bottom_right", "chroma_blue", "chroma_red"};

    rgb_quad_to_yuv420 dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int clamp8(int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    function automatic yuv_t predict_yuv(quad_t q, bit wide, bit swapped);
        int   red[4], grn[4], blu[4];
        int   kyr, kyg, kyb, kur, kug, kub, kvr, kvg, kvb;
        int   sum_r, sum_g, sum_b, avg_r, avg_g, avg_b, y;
        yuv_t res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (int p = 0; p < 4; p++)
        begin
            grn[p] = int'(q[p*3+1]);
            red[p] = swapped ? int'(q[p*3+2]) : int'(q[p*3]);
            blu[p] = swapped ? int'(q[p*3])   : int'(q[p*3+2]);
            sum_r += red[p];
            sum_g += grn[p];
            sum_b += blu[p];
        end
        if (wide)
        begin
            kyr = 54;  kyg = 183;  kyb = 18;
            kur = -29; kug = -98;  kub = 127;
            kvr = 127; kvg = -115; kvb = -11;
        end
        else
        begin
            kyr = 46;  kyg = 157;  kyb = 15;
            kur = -25; kug = -86;  kub = 112;
            kvr = 112; kvg = -102; kvb = -10;
        end
        for (int p = 0; p < 4; p++)
        begin
            y = (red[p] * kyr + grn[p] * kyg + blu[p] * kyb) >>> 8;
            if (!wide)
                y += 16;
            res[p] = 8'(clamp8(y));
        end
        avg_r = sum_r >>> 2;
        avg_g = sum_g >>> 2;
        avg_b = sum_b >>> 2;
        res[4] = 8'(clamp8(((avg_r * kur + avg_g * kug + avg_b * kub) >>> 8) + 128));
        res[5] = 8'(clamp8(((avg_r * kvr + avg_g * kvg + avg_b * kvb) >>> 8) + 128));
        return res;
    endfunction

    function automatic quad_t uniform_quad(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        quad_t q;
        for (int p = 0; p < 4; p++)
            {q[p*3+2], q[p*3+1], q[p*3]} = {c2, c1, c0};
        return q;
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        for (int i = 0; i < 12; i++)
        begin
            case ($urandom_range(0, 7))
                0:       q[i] = 8'd0;
                1:       q[i] = 8'd255;
                default: q[i] = 8'($urandom_range(0, 255));
            endcase
        end
        return q;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic send_quad(quad_t q);
        while (gaps_on && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {bottom_right_c2, bottom_right_c1, bottom_right_c0,
         bottom_left_c2, bottom_left_c1, bottom_left_c0,
         top_right_c2, top_right_c1, top_right_c0,
         top_left_c2, top_left_c1, top_left_c0} <= q;
        do
            @(posedge clk);
        while (in_stall);
        yuv_expected.push_back(predict_yuv(q, mode_full_range, mode_swap_rb));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (yuv_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(bit wide, bit swapped);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_FULL_RANGE;
        cfg_data  <= wide;
        @(posedge clk);
        cfg_index <= CFG_SWAP_RED_BLUE;
        cfg_data  <= swapped;
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_full_range = wide;
        mode_swap_rb    = swapped;
    endtask

    always @(posedge clk)
    begin : check_result
        yuv_t seen;
        yuv_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {chroma_red, chroma_blue, luma_bottom_right, luma_bottom_left,
                    luma_top_right, luma_top_left};
            if (yuv_expected.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = yuv_expected.pop_front();
                for (int i = 0; i < 6; i++)
                    if (seen[i] !== want[i])
                        report_mismatch($sformatf("%s got %0d want %0d",
                                                  yuv_field[i], seen[i], want[i]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (stalls_on && $urandom_range(0, 99) < 13);
    end

    task automatic run_directed_set();
        quad_t q;
        send_quad(uniform_quad(8'd0, 8'd0, 8'd0));
        send_quad(uniform_quad(8'd255, 8'd255, 8'd255));
        send_quad(uniform_quad(8'd255, 8'd0, 8'd0));
        send_quad(uniform_quad(8'd0, 8'd255, 8'd0));
        send_quad(uniform_quad(8'd0, 8'd0, 8'd255));
        send_quad({12{8'h55}});
        send_quad({12{8'hAA}});
        // alternate black and white pixels across the quad
        q = '0;
        {q[2], q[1], q[0]}   = {3{8'd255}};
        {q[11], q[10], q[9]} = {3{8'd255}};
        send_quad(q);
        // uneven channel sums and green-heavy negative chroma
        {q[2], q[1], q[0]}    = {8'd1, 8'd255, 8'd3};
        {q[5], q[4], q[3]}    = {8'd0, 8'd254, 8'd2};
        {q[8], q[7], q[6]}    = {8'd2, 8'd253, 8'd0};
        {q[11], q[10], q[9]}  = {8'd0, 8'd255, 8'd1};
        send_quad(q);
    endtask

    task automatic test_directed();
        gaps_on = 1'b0;
        stalls_on <= 1'b0;
        run_directed_set();
        write_config(1'b1, 1'b1);
        run_directed_set();
    endtask

    task automatic test_mode_sweep();
        gaps_on = 1'b1;
        stalls_on <= 1'b1;
        for (int m = 0; m < 4; m++)
        begin
            write_config(m[0], m[1]);
            repeat (150)
                send_quad(random_quad());
        end
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        stalls_on <= 1'b0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (60)
                    @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (40)
            send_quad(random_quad());
        drain();
    endtask

    task automatic test_random_traffic();
        for (int blk = 0; blk < 6; blk++)
        begin
            write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            // keep the third block free of gaps and stalls
            gaps_on = (blk != 2);
            stalls_on <= (blk != 2);
            repeat (200)
                send_quad(random_quad());
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_FULL_RANGE;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        {bottom_right_c2, bottom_right_c1, bottom_right_c0,
         bottom_left_c2, bottom_left_c1, bottom_left_c0,
         top_right_c2, top_right_c1, top_right_c0,
         top_left_c2, top_left_c1, top_left_c0} = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_mode_sweep();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/rqy_pkg.sv
design/rqy_luma_lane.sv
design/rqy_chroma_merge.sv
design/rgb_quad_to_yuv420.sv
test/testbench.sv
